// File: rtl/core/arp_cache_with_aging_top_defines.svh
// ---------------------------------------------------------------------------
// ARP cache assertion macros
// Shared property forms for the checker of the ARP cache.
// ---------------------------------------------------------------------------
`ifndef ARP_CACHE_WITH_AGING_TOP_DEFINES_SVH
`define ARP_CACHE_WITH_AGING_TOP_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ARPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/arpc_pkg.sv
// ---------------------------------------------------------------------------
// ARP cache package
// Widths, codes and the command item passed from front to back.
// ---------------------------------------------------------------------------
package arpc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int MAC_W       = 48;
  localparam int IP_W        = 32;
  localparam int TIME_W      = 32;
  localparam int AGE_W       = 16;
  localparam int CNT_W       = 5;

  localparam logic [AGE_W-1:0] MAX_AGE_RST = 16'd15;
  localparam logic [CNT_W-1:0] CNT_MAX     = 5'd31;

  localparam logic [1:0] MODE_LEARN  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_SWEEP  = 2'd2;

  typedef enum logic [1:0] {
    OP_LEARN  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [TIME_W-1:0] now;
  } cmd_t;

endpackage

// File: rtl/core/arpc_ram.sv
// ---------------------------------------------------------------------------
// ARP cache RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module arpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/arpc_front.sv
// ---------------------------------------------------------------------------
// ARP cache front end
// Accepts items, decodes the mode and queues commands for the back end.
// ---------------------------------------------------------------------------
module arpc_front import arpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic [MAC_W-1:0]  mac_addr,
  input  logic [IP_W-1:0]   ip_addr,
  input  logic [TIME_W-1:0] now_seconds,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t       q [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       push;
  op_t        op_dec;

  always_comb begin
    case (mode)
      MODE_LEARN:  op_dec = OP_LEARN;
      MODE_LOOKUP: op_dec = OP_LOOKUP;
      MODE_SWEEP:  op_dec = OP_SWEEP;
      default:     op_dec = OP_NOP;
    endcase
  end

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[head];

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= '{op: op_dec, mac: mac_addr, ip: ip_addr, now: now_seconds};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (cmd_pop) begin
        head <= ~head;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/arpc_back.sv
// ---------------------------------------------------------------------------
// ARP cache back end
// Scans the entry RAMs one entry a cycle and carries out each command.
// ---------------------------------------------------------------------------
module arpc_back import arpc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [AGE_W-1:0]  max_age,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              done,
  output logic              hit,
  output logic [MAC_W-1:0]  found_mac,
  output logic              table_full,
  output logic [CNT_W-1:0]  newly_expired
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [CW-1:0]     rd_cnt;
  logic              cmp_vld;
  logic [IW-1:0]     cmp_idx;
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] alive;
  logic              slot_found;
  logic [IW-1:0]     slot_idx;

  logic [MAC_W-1:0]  mac_q;
  logic [IP_W-1:0]   ip_q;
  logic [TIME_W-1:0] stamp_q;

  logic              issue;
  logic              ent_v;
  logic              ent_a;
  logic              mac_match;
  logic              ip_match;
  logic              expire;
  logic              free;
  logic              last;
  logic [TIME_W-1:0] age;
  logic              stamp_we;
  logic [IW-1:0]     stamp_wa;

  assign issue   = (state == ST_SCAN) && (rd_cnt < CW'(ENTRIES));
  assign cmd_pop = (state == ST_IDLE) && cmd_valid;
  assign done    = (state == ST_DONE);

  assign ent_v     = valid[cmp_idx];
  assign ent_a     = alive[cmp_idx];
  assign age       = cur.now - stamp_q;
  assign mac_match = cmp_vld && (cur.op == OP_LEARN) && ent_v && (mac_q == cur.mac);
  assign ip_match  = cmp_vld && (cur.op == OP_LOOKUP) && ent_v && ent_a && (ip_q == cur.ip);
  assign expire    = cmp_vld && (cur.op == OP_SWEEP) && ent_v && ent_a &&
                     (age >= {{(TIME_W-AGE_W){1'b0}}, max_age});
  assign free      = !ent_v || !ent_a;
  assign last      = cmp_vld && (cmp_idx == IW'(ENTRIES - 1));

  // refresh writes stamps during the scan; new entries write after it
  assign stamp_we = (state == ST_WRITE) || ((state == ST_SCAN) && mac_match);
  assign stamp_wa = (state == ST_WRITE) ? slot_idx : cmp_idx;

  arpc_ram #(.WIDTH(MAC_W), .DEPTH(ENTRIES)) u_mac_ram (
    .clk     (clk),
    .wr_en   (state == ST_WRITE),
    .wr_addr (slot_idx),
    .wr_data (cur.mac),
    .rd_addr (rd_cnt[IW-1:0]),
    .rd_data (mac_q)
  );

  arpc_ram #(.WIDTH(IP_W), .DEPTH(ENTRIES)) u_ip_ram (
    .clk     (clk),
    .wr_en   (state == ST_WRITE),
    .wr_addr (slot_idx),
    .wr_data (cur.ip),
    .rd_addr (rd_cnt[IW-1:0]),
    .rd_data (ip_q)
  );

  arpc_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_stamp_ram (
    .clk     (clk),
    .wr_en   (stamp_we),
    .wr_addr (stamp_wa),
    .wr_data (cur.now),
    .rd_addr (rd_cnt[IW-1:0]),
    .rd_data (stamp_q)
  );

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_cnt        <= '0;
      cmp_vld       <= 1'b0;
      cmp_idx       <= '0;
      valid         <= '0;
      alive         <= '0;
      slot_found    <= 1'b0;
      slot_idx      <= '0;
      hit           <= 1'b0;
      found_mac     <= '0;
      table_full    <= 1'b0;
      newly_expired <= '0;
    end else begin
      cmp_vld <= issue;
      cmp_idx <= rd_cnt[IW-1:0];
      if (issue) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            rd_cnt        <= '0;
            slot_found    <= 1'b0;
            hit           <= 1'b0;
            found_mac     <= '0;
            table_full    <= 1'b0;
            newly_expired <= '0;
            state         <= (cmd.op == OP_NOP) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (mac_match) begin
            hit            <= 1'b1;
            alive[cmp_idx] <= 1'b1;
          end
          if (ip_match && !hit) begin
            hit       <= 1'b1;
            found_mac <= mac_q;
          end
          if (expire) begin
            alive[cmp_idx] <= 1'b0;
            if (newly_expired != CNT_MAX) begin
              newly_expired <= newly_expired + CNT_W'(1);
            end
          end
          if (cmp_vld && free && !slot_found) begin
            slot_found <= 1'b1;
            slot_idx   <= cmp_idx;
          end
          if (last) begin
            if ((cur.op == OP_LEARN) && !hit && !mac_match) begin
              if (slot_found || free) begin
                state <= ST_WRITE;
              end else begin
                table_full <= 1'b1;
                state      <= ST_DONE;
              end
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_WRITE: begin
          valid[slot_idx] <= 1'b1;
          alive[slot_idx] <= 1'b1;
          state           <= ST_DONE;
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/arp_cache_with_aging_top.sv
// ---------------------------------------------------------------------------
// ARP cache with aging
// MAC/IP pair cache with learn, lookup and aging sweep commands.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: an item (mode, mac_addr, ip_addr, now_seconds) is taken
//   at a clock edge with start high and busy low. A two-deep queue sits
//   between the decoder and the scan engine, so busy rises only when both
//   slots hold waiting items.
//   Result channel: done is high one cycle per item, with hit, found_mac,
//   table_full and newly_expired valid then, in item order; it cannot stall.
//   Config channel: cfg_ready is always high; cfg_data loads max_age when
//   cfg_valid is high. Write it only while no item is in flight.
//   Scan: the back end reads one entry a cycle from the RAMs; a learn with
//   no match and a free slot writes a new entry after the scan, and an
//   unused mode skips the scan. A queued item waits for the one ahead, as
//   the back end starts an item only once the one before it is done.
//   Reset: synchronous; clears the queue, all valid and alive bits and sets
//   max_age to 15. Entry RAM contents need no clearing.
// ---------------------------------------------------------------------------
module arp_cache_with_aging_top import arpc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic [MAC_W-1:0]  mac_addr,
  input  logic [IP_W-1:0]   ip_addr,
  input  logic [TIME_W-1:0] now_seconds,
  output logic              done,
  output logic              hit,
  output logic [MAC_W-1:0]  found_mac,
  output logic              table_full,
  output logic [CNT_W-1:0]  newly_expired,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [AGE_W-1:0]  cfg_data
);

  logic [AGE_W-1:0] max_age;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= MAX_AGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_age <= cfg_data;
    end
  end

  arpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .mac_addr    (mac_addr),
    .ip_addr     (ip_addr),
    .now_seconds (now_seconds),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  arpc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .max_age       (max_age),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .done          (done),
    .hit           (hit),
    .found_mac     (found_mac),
    .table_full    (table_full),
    .newly_expired (newly_expired)
  );

endmodule

// File: rtl/core/arpc_checker.sv
// ---------------------------------------------------------------------------
// ARP cache checker
// Port-level checks on result items, bound to the top level.
// ---------------------------------------------------------------------------
`include "arp_cache_with_aging_top_defines.svh"

module arpc_checker import arpc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             done,
  input logic             hit,
  input logic [MAC_W-1:0] found_mac,
  input logic             table_full,
  input logic [CNT_W-1:0] newly_expired
);

  // each item ends with a single-cycle result and a return to idle
  `ARPC_ASSERT_NEXT(a_done_single, done, !done, "done held for two cycles")

  `ARPC_ASSERT_SAME(a_full_no_hit, done && table_full, !hit, "table_full with hit")

  `ARPC_ASSERT_SAME(a_mac_needs_hit, done && (found_mac != '0), hit && !table_full,
                    "found_mac without a lookup hit")

  `ARPC_ASSERT_SAME(a_sweep_only, done && (newly_expired != '0), !hit && !table_full,
                    "expire count mixed with other results")

endmodule

bind arp_cache_with_aging_top arpc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .done          (done),
  .hit           (hit),
  .found_mac     (found_mac),
  .table_full    (table_full),
  .newly_expired (newly_expired)
);
